// ----- hdl/pinpoly_pkg.sv -----
package pinpoly_pkg;

  // Table size and coordinate precision
  localparam int MAX_VERTICES = 16;
  localparam int COORD_BITS   = 16;

  localparam int IDX_W  = $clog2(MAX_VERTICES);
  localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
  localparam int FLD_W  = 16;               // width of a coordinate field on the port
  localparam int VCNT_W = 5;                // width of the vertex_count field
  localparam int DIFF_W = COORD_BITS + 1;   // coordinate difference
  localparam int PROD_W = 2 * DIFF_W;       // one product term
  localparam int SUM_W  = PROD_W + 2;       // sum of three product terms

  typedef logic        [IDX_W-1:0]      idx_t;
  typedef logic        [CNT_W-1:0]      cnt_t;
  typedef logic        [VCNT_W-1:0]     vcnt_t;
  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]     diff_t;
  typedef logic signed [PROD_W-1:0]     prod_t;
  typedef logic signed [SUM_W-1:0]      sum_t;

  typedef enum logic [1:0] {
    REQ_CLEAR  = 2'd0,
    REQ_APPEND = 2'd1,
    REQ_TEST   = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_FULL = 2'd1,
    STAT_FEW  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DRAIN
  } state_e;

  // Request payload
  typedef struct packed {
    req_e                     req_type;
    logic signed [FLD_W-1:0]  x_coord;
    logic signed [FLD_W-1:0]  y_coord;
    logic signed [FLD_W-1:0]  z_coord;
  } req_t;

  // Result payload
  typedef struct packed {
    logic    inside_res;
    status_e status;
    vcnt_t   vertex_count;
  } res_t;

  // One table entry
  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } vtx_t;

  localparam int VTX_W = $bits(vtx_t);

  // Field value to internal coordinate: keep the low COORD_BITS bits
  function automatic coord_t to_coord(logic [FLD_W-1:0] raw);
    return coord_t'(raw);
  endfunction

endpackage

// ----- hdl/pinpoly_ram.sv -----
module pinpoly_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/point_in_convex_polygon_test.sv -----
// Point-in-convex-polygon test. Vertices (counter-clockwise) are appended
// one request at a time into an on-chip table of MAX_VERTICES entries; a
// test request walks every edge, closing edge included, and reports the
// point inside when no edge gives a positive cross term. Each request gives
// exactly one result, shown for a single cycle with res_valid_o high; the
// receiver cannot stall it, so it must take the result in that cycle.
// Clear, append and the unused code give their result the cycle after
// start is taken and never raise busy, so such requests may go back to
// back. A test on a table of n >= 2 vertices reads the table once through
// its single read port, one entry per cycle (n + 1 reads, the first entry
// read again to close the polygon), followed by a three-stage arithmetic
// pipeline: busy stays high until the closing edge has passed the last
// stage, whose verdict is then registered as the result. A test on
// fewer than two vertices answers the next cycle with status "too few".
// The table needs no clearing after reset; the vertex count is reset to zero.
module point_in_convex_polygon_test (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  pinpoly_pkg::req_t  req_i,
  output logic               res_valid_o,
  output pinpoly_pkg::res_t  res_o
);

  pinpoly_pkg::state_e st_q, st_d;

  // vertex count
  pinpoly_pkg::cnt_t cnt_q, cnt_d;

  // read walk: step runs 0..count, last step re-reads entry 0
  pinpoly_pkg::cnt_t step_q, step_d;

  // query point and sticky "outside" flag
  pinpoly_pkg::vtx_t qry_q, qry_d;
  logic              out_q, out_d;

  // result register
  pinpoly_pkg::res_t res_q, res_d;
  logic              res_vld_q, res_vld_d;

  logic              accept;
  logic              last_rd;
  logic              few;
  logic              full;
  pinpoly_pkg::vtx_t in_vtx;

  // RAM ports
  logic              ram_we;
  logic              ram_re;
  pinpoly_pkg::idx_t ram_raddr;
  pinpoly_pkg::vtx_t ram_rdata;

  // read return (stage 0)
  logic v0_q, first0_q, last0_q;
  // stage A: differences
  logic               vA_q, lastA_q;
  pinpoly_pkg::vtx_t  prev_q;
  pinpoly_pkg::diff_t dx_q, dy_q, dz_q, ax_q, ay_q, az_q;
  // stage B: products
  logic               vB_q, lastB_q, nzB_q;
  pinpoly_pkg::prod_t p1_q, p2_q, p3_q;
  // stage C: sum and sign
  pinpoly_pkg::sum_t  edge_sum;
  logic               edge_out;
  logic               walk_done;

  assign accept  = start && !busy;
  assign busy    = (st_q != pinpoly_pkg::ST_IDLE);
  assign last_rd = (step_q == cnt_q);
  assign few     = (cnt_q < pinpoly_pkg::cnt_t'(2));
  assign full    = (cnt_q == pinpoly_pkg::cnt_t'(pinpoly_pkg::MAX_VERTICES));

  assign in_vtx.x = pinpoly_pkg::to_coord(req_i.x_coord);
  assign in_vtx.y = pinpoly_pkg::to_coord(req_i.y_coord);
  assign in_vtx.z = pinpoly_pkg::to_coord(req_i.z_coord);

  // ---------------------------------------------------------------------
  // Vertex table
  // ---------------------------------------------------------------------
  pinpoly_ram #(
    .WIDTH (pinpoly_pkg::VTX_W),
    .DEPTH (pinpoly_pkg::MAX_VERTICES)
  ) u_vtx_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cnt_q[pinpoly_pkg::IDX_W-1:0]),
    .wdata_i (in_vtx),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // closing edge: the read after the last entry goes back to entry 0
  assign ram_re    = (st_q == pinpoly_pkg::ST_READ);
  assign ram_raddr = last_rd ? '0 : step_q[pinpoly_pkg::IDX_W-1:0];

  // ---------------------------------------------------------------------
  // Edge pipeline
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q     <= 1'b0;
      first0_q <= 1'b0;
      last0_q  <= 1'b0;
      vA_q     <= 1'b0;
      lastA_q  <= 1'b0;
      vB_q     <= 1'b0;
      lastB_q  <= 1'b0;
    end else begin
      v0_q     <= ram_re;
      first0_q <= (step_q == '0);
      last0_q  <= last_rd;
      vA_q     <= v0_q && !first0_q;
      lastA_q  <= v0_q && last0_q;
      vB_q     <= vA_q;
      lastB_q  <= vA_q && lastA_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (v0_q) begin
      prev_q <= ram_rdata;
      dx_q   <= pinpoly_pkg::diff_t'(ram_rdata.x) - pinpoly_pkg::diff_t'(prev_q.x);
      dy_q   <= pinpoly_pkg::diff_t'(ram_rdata.y) - pinpoly_pkg::diff_t'(prev_q.y);
      dz_q   <= pinpoly_pkg::diff_t'(ram_rdata.z) - pinpoly_pkg::diff_t'(prev_q.z);
      ax_q   <= pinpoly_pkg::diff_t'(qry_q.x) - pinpoly_pkg::diff_t'(prev_q.x);
      ay_q   <= pinpoly_pkg::diff_t'(qry_q.y) - pinpoly_pkg::diff_t'(prev_q.y);
      az_q   <= pinpoly_pkg::diff_t'(qry_q.z) - pinpoly_pkg::diff_t'(prev_q.z);
    end
    if (vA_q) begin
      p1_q  <= dy_q * ax_q;
      p2_q  <= dx_q * ay_q;
      p3_q  <= dz_q * az_q;
      nzB_q <= (dx_q != '0) || (dy_q != '0) || (dz_q != '0);
    end
  end

  // s = dy*ax - dx*ay + dz*az; zero-length edges never count as outside
  assign edge_sum = pinpoly_pkg::sum_t'(p1_q) - pinpoly_pkg::sum_t'(p2_q)
                  + pinpoly_pkg::sum_t'(p3_q);
  assign edge_out = vB_q && nzB_q && !edge_sum[pinpoly_pkg::SUM_W-1]
                  && (edge_sum != '0);
  assign walk_done = (st_q == pinpoly_pkg::ST_DRAIN) && vB_q && lastB_q;

  // ---------------------------------------------------------------------
  // Control: next state
  // ---------------------------------------------------------------------
  always_comb begin
    st_d = st_q;
    case (st_q)
      pinpoly_pkg::ST_IDLE: begin
        if (accept && (req_i.req_type == pinpoly_pkg::REQ_TEST) && !few) begin
          st_d = pinpoly_pkg::ST_READ;
        end
      end
      pinpoly_pkg::ST_READ: begin
        if (last_rd) begin
          st_d = pinpoly_pkg::ST_DRAIN;
        end
      end
      pinpoly_pkg::ST_DRAIN: begin
        if (walk_done) begin
          st_d = pinpoly_pkg::ST_IDLE;
        end
      end
      default: begin
        st_d = pinpoly_pkg::ST_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------
  // Control: outputs and datapath updates
  // ---------------------------------------------------------------------
  always_comb begin
    cnt_d     = cnt_q;
    step_d    = step_q;
    qry_d     = qry_q;
    out_d     = out_q || edge_out;
    res_d     = res_q;
    res_vld_d = 1'b0;
    ram_we    = 1'b0;

    if (st_q == pinpoly_pkg::ST_READ) begin
      step_d = step_q + pinpoly_pkg::cnt_t'(1);
    end

    if (accept) begin
      res_d.inside_res = 1'b0;
      res_d.status     = pinpoly_pkg::STAT_OK;
      res_vld_d        = 1'b1;
      case (req_i.req_type)
        pinpoly_pkg::REQ_CLEAR: begin
          cnt_d = '0;
        end
        pinpoly_pkg::REQ_APPEND: begin
          if (full) begin
            res_d.status = pinpoly_pkg::STAT_FULL;
          end else begin
            ram_we = 1'b1;
            cnt_d  = cnt_q + pinpoly_pkg::cnt_t'(1);
          end
        end
        pinpoly_pkg::REQ_TEST: begin
          if (few) begin
            res_d.status = pinpoly_pkg::STAT_FEW;
          end else begin
            // answer comes at the end of the walk
            res_vld_d = 1'b0;
            qry_d     = in_vtx;
            step_d    = '0;
            out_d     = 1'b0;
          end
        end
        default: begin
          // unused code: no state change
        end
      endcase
      res_d.vertex_count = pinpoly_pkg::vcnt_t'(cnt_d);
    end

    if (walk_done) begin
      res_d.inside_res   = !(out_q || edge_out);
      res_d.status       = pinpoly_pkg::STAT_OK;
      res_d.vertex_count = pinpoly_pkg::vcnt_t'(cnt_q);
      res_vld_d          = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= pinpoly_pkg::ST_IDLE;
      cnt_q     <= '0;
      step_q    <= '0;
      out_q     <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      st_q      <= st_d;
      cnt_q     <= cnt_d;
      step_q    <= step_d;
      out_q     <= out_d;
      res_vld_q <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    qry_q <= qry_d;
    res_q <= res_d;
  end

  assign res_valid_o = res_vld_q;
  assign res_o       = res_q;

endmodule
